// ===== sv/mfde_pkg.sv =====
`timescale 1ns / 1ps

package mfde_pkg;

  // Default panel geometry
  localparam int PANEL_W_DEF = 296;
  localparam int PANEL_H_DEF = 128;

  // Bit mask of the leftmost pixel in a byte
  localparam logic [7:0] PIX_MASK_MSB = 8'h80;

  typedef enum logic [2:0] {
    REQ_PLOT       = 3'd0,
    REQ_FILL       = 3'd1,
    REQ_BLIT_START = 3'd2,
    REQ_BLIT_BYTE  = 3'd3,
    REQ_READ       = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_NO_BLIT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ROT_0 = 2'd0,
    ROT_1 = 2'd1,
    ROT_2 = 2'd2,
    ROT_3 = 2'd3
  } rot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_PIX_WR,
    ST_BLIT_STEP,
    ST_BLIT_END,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       in_range;
    logic [7:0] mask;
  } pix_hit_t;

endpackage

// ===== sv/mfde_ram.sv =====
`timescale 1ns / 1ps

module mfde_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 4736
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mfde_pix_map.sv =====
`timescale 1ns / 1ps

module mfde_pix_map import mfde_pkg::*; #(
  parameter int PANEL_W = PANEL_W_DEF,
  parameter int PANEL_H = PANEL_H_DEF,
  parameter int AW      = 13
) (
  input  logic [9:0]    px,
  input  logic [9:0]    py,
  input  rot_t          rotation,
  output logic [AW-1:0] addr,
  output pix_hit_t      hit
);

  localparam logic [9:0] W_LIM    = 10'(PANEL_W);
  localparam logic [9:0] H_LIM    = 10'(PANEL_H);
  localparam logic [9:0] W_M1     = 10'(PANEL_W - 1);
  localparam logic [9:0] H_M1     = 10'(PANEL_H - 1);
  localparam logic [6:0] STRIDE_H = 7'((PANEL_H + 7) / 8);
  localparam logic [6:0] STRIDE_W = 7'((PANEL_W + 7) / 8);

  logic [9:0]  col;
  logic [9:0]  row;
  logic [6:0]  stride;
  logic [15:0] row_off;
  logic [15:0] byte_addr;

  always_comb begin
    unique case (rotation)
      ROT_0: begin
        col    = H_M1 - py;
        row    = px;
        stride = STRIDE_H;
      end
      ROT_1: begin
        col    = px;
        row    = py;
        stride = STRIDE_W;
      end
      ROT_2: begin
        col    = py;
        row    = W_M1 - px;
        stride = STRIDE_H;
      end
      ROT_3: begin
        col    = W_M1 - px;
        row    = H_M1 - py;
        stride = STRIDE_W;
      end
      default: begin
        col    = px;
        row    = py;
        stride = STRIDE_W;
      end
    endcase
  end

  assign row_off      = 16'(row[8:0]) * 16'(stride);
  assign byte_addr    = 16'(col[8:3]) + row_off;
  assign addr         = byte_addr[AW-1:0];
  assign hit.in_range = (px < W_LIM) && (py < H_LIM);
  assign hit.mask     = PIX_MASK_MSB >> col[2:0];

endmodule

// ===== sv/mono_framebuffer_draw_engine.sv =====
`timescale 1ns / 1ps

// One-bit-per-pixel framebuffer draw engine. Requests plot a pixel, fill a
// rectangle (end exclusive), start a bitmap blit, feed one MSB-first blit byte or
// read one framebuffer byte inverted for the panel; each request returns exactly
// one result transaction. The framebuffer lives in a single synchronous RAM of
// ceil(PANEL_H/8)*PANEL_W or ceil(PANEL_W/8)*PANEL_H bytes, whichever is larger
// (4736 bytes by default). After reset the engine sweeps the RAM to zero, one
// byte per cycle, and in_stall stays high until the sweep is done;
// configuration writes are taken throughout. Every pixel on the panel is a
// read-modify-write of the RAM: a read in ST_PIX, then the write back in
// ST_PIX_WR; a pixel off the panel is not written. A read past the store, a
// blit start, an unknown request and a blit byte with no blit open finish
// without touching the RAM. A fill visits each pixel inside the clipped
// rectangle in turn, and a blit byte visits its bits MSB-first, dropping
// those past the row width, before closing the byte in ST_BLIT_END.
// The engine accepts the next transaction in the cycle after the previous result
// is handed to the output register, which holds it while the sink stalls.
// Rotation is set through the cfg port and must only change while idle.
module mono_framebuffer_draw_engine import mfde_pkg::*; #(
  parameter int PANEL_W = PANEL_W_DEF,
  parameter int PANEL_H = PANEL_H_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [8:0]  in_x,
  input  logic [8:0]  in_y,
  input  logic [9:0]  in_x_end,
  input  logic [9:0]  in_y_end,
  input  logic [9:0]  in_width,
  input  logic [9:0]  in_height,
  input  logic        in_ink,
  input  logic [7:0]  in_data_byte,
  input  logic [12:0] in_byte_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_data,
  output logic        out_blit_done,
  // rotation register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_rotation
);

  localparam int SIZE_A   = ((PANEL_H + 7) / 8) * PANEL_W;
  localparam int SIZE_B   = ((PANEL_W + 7) / 8) * PANEL_H;
  localparam int FB_BYTES = (SIZE_A > SIZE_B) ? SIZE_A : SIZE_B;
  localparam int AW       = $clog2(FB_BYTES);

  localparam logic [AW-1:0] LAST_ADDR  = AW'(FB_BYTES - 1);
  localparam logic [15:0]   FB_BYTES_W = 16'(FB_BYTES);
  localparam logic [9:0]    W_LIM      = 10'(PANEL_W);
  localparam logic [9:0]    H_LIM      = 10'(PANEL_H);

  // control state
  state_t        state_r, state_nxt;
  rot_t          rot_r;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  // blit context, lives across transactions
  logic [9:0]    cur_x_r, cur_x_nxt;
  logic [9:0]    cur_y_r, cur_y_nxt;
  logic [8:0]    org_x_r, org_x_nxt;
  logic [9:0]    bw_r, bw_nxt;
  logic [15:0]   bleft_r, bleft_nxt;
  logic          bink_r, bink_nxt;
  // working registers of the current transaction
  req_t          op_r, op_nxt;
  logic [9:0]    px_r, px_nxt;
  logic [9:0]    py_r, py_nxt;
  logic          colour_r, colour_nxt;
  logic [8:0]    x0_r, x0_nxt;
  logic [9:0]    xlim_r, xlim_nxt;
  logic [9:0]    ylim_r, ylim_nxt;
  logic [7:0]    bdata_r, bdata_nxt;
  logic [2:0]    bcnt_r, bcnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]    mask_r, mask_nxt;
  status_t       status_r, status_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic          done_r, done_nxt;
  // output register
  status_t       out_status_r, out_status_nxt;
  logic [7:0]    out_rd_r, out_rd_nxt;
  logic          out_done_r, out_done_nxt;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // pixel mapping
  logic [AW-1:0] map_addr;
  pix_hit_t      map_hit;

  // helpers
  logic          slot_free;
  logic          finish;
  logic          pix_done;
  logic          blit_stop;
  logic [9:0]    cur_dx;
  logic [10:0]   w_round;
  logic [17:0]   blit_total;
  logic [15:0]   bidx_w;
  logic [9:0]    x_ext;
  logic [9:0]    y_ext;
  logic [9:0]    fill_xlim;
  logic [9:0]    fill_ylim;
  logic [9:0]    px_inc;
  logic [9:0]    py_inc;

  mfde_ram #(
    .DW    (8),
    .DEPTH (FB_BYTES)
  ) u_fb_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mfde_pix_map #(
    .PANEL_W (PANEL_W),
    .PANEL_H (PANEL_H),
    .AW      (AW)
  ) u_pix_map (
    .px       (px_r),
    .py       (py_r),
    .rotation (rot_r),
    .addr     (map_addr),
    .hit      (map_hit)
  );

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_rd_r;
  assign out_blit_done = out_done_r;
  assign cfg_ready     = 1'b1;

  assign slot_free = !out_valid_r || !out_stall;

  // The blit row ends once the cursor has left [origin, origin + width);
  // a cursor that wrapped below the origin counts as past the end.
  assign cur_dx    = cur_x_r - {1'b0, org_x_r};
  assign blit_stop = (cur_x_r < {1'b0, org_x_r}) || (cur_dx >= bw_r);

  assign w_round    = {1'b0, in_width} + 11'd7;
  assign blit_total = 18'(w_round[10:3]) * 18'(in_height);
  assign bidx_w     = 16'(in_byte_index);
  assign x_ext      = {1'b0, in_x};
  assign y_ext      = {1'b0, in_y};
  assign fill_xlim  = (in_x_end < W_LIM) ? in_x_end : W_LIM;
  assign fill_ylim  = (in_y_end < H_LIM) ? in_y_end : H_LIM;
  assign px_inc     = px_r + 10'd1;
  assign py_inc     = py_r + 10'd1;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    org_x_nxt      = org_x_r;
    bw_nxt         = bw_r;
    bleft_nxt      = bleft_r;
    bink_nxt       = bink_r;
    op_nxt         = op_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    colour_nxt     = colour_r;
    x0_nxt         = x0_r;
    xlim_nxt       = xlim_r;
    ylim_nxt       = ylim_r;
    bdata_nxt      = bdata_r;
    bcnt_nxt       = bcnt_r;
    addr_nxt       = addr_r;
    mask_nxt       = mask_r;
    status_nxt     = status_r;
    rd_nxt         = rd_r;
    done_nxt       = done_r;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_done_nxt   = out_done_r;
    out_valid_nxt  = out_valid_r && out_stall;

    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = colour_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
    ram_re    = 1'b0;
    ram_raddr = map_addr;

    finish   = 1'b0;
    pix_done = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        // sweep the framebuffer to white
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 8'd0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = STAT_OK;
          rd_nxt     = 8'd0;
          done_nxt   = 1'b0;
          op_nxt     = req_t'(in_req_type);
          unique case (req_t'(in_req_type))
            REQ_PLOT: begin
              px_nxt     = x_ext;
              py_nxt     = y_ext;
              colour_nxt = in_ink;
              state_nxt  = ST_PIX;
            end
            REQ_FILL: begin
              if ((x_ext < in_x_end) && (y_ext < in_y_end) &&
                  ((in_x_end > W_LIM) || (in_y_end > H_LIM))) begin
                status_nxt = STAT_RANGE;
              end
              px_nxt     = x_ext;
              py_nxt     = y_ext;
              x0_nxt     = in_x;
              xlim_nxt   = fill_xlim;
              ylim_nxt   = fill_ylim;
              colour_nxt = in_ink;
              // clip to the panel; an empty clip draws nothing
              if ((x_ext < fill_xlim) && (y_ext < fill_ylim)) begin
                state_nxt = ST_PIX;
              end else begin
                finish = 1'b1;
              end
            end
            REQ_BLIT_START: begin
              bleft_nxt = (blit_total > 18'h0FFFF) ? 16'hFFFF : blit_total[15:0];
              org_x_nxt = in_x;
              cur_x_nxt = x_ext;
              cur_y_nxt = y_ext;
              bw_nxt    = in_width;
              bink_nxt  = in_ink;
              finish    = 1'b1;
            end
            REQ_BLIT_BYTE: begin
              if (bleft_r == 16'd0) begin
                status_nxt = STAT_NO_BLIT;
                finish     = 1'b1;
              end else begin
                bdata_nxt = in_data_byte;
                bcnt_nxt  = 3'd0;
                state_nxt = ST_BLIT_STEP;
              end
            end
            REQ_READ: begin
              if (bidx_w < FB_BYTES_W) begin
                ram_re    = 1'b1;
                ram_raddr = bidx_w[AW-1:0];
                state_nxt = ST_READ_WAIT;
              end else begin
                status_nxt = STAT_RANGE;
                finish     = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      ST_PIX: begin
        // read half of the read-modify-write; the write lands before the
        // next read can be issued, so no forwarding is needed
        addr_nxt = map_addr;
        mask_nxt = map_hit.mask;
        if (map_hit.in_range) begin
          ram_re    = 1'b1;
          state_nxt = ST_PIX_WR;
        end else begin
          status_nxt = STAT_RANGE;
          pix_done   = 1'b1;
        end
      end

      ST_PIX_WR: begin
        ram_we   = 1'b1;
        pix_done = 1'b1;
      end

      ST_BLIT_STEP: begin
        if (blit_stop) begin
          // drop padding bits past the row width
          state_nxt = ST_BLIT_END;
        end else begin
          px_nxt     = cur_x_r;
          py_nxt     = cur_y_r;
          colour_nxt = bdata_r[7] ? bink_r : !bink_r;
          state_nxt  = ST_PIX;
        end
      end

      ST_BLIT_END: begin
        if (blit_stop) begin
          cur_x_nxt = {1'b0, org_x_r};
          cur_y_nxt = cur_y_r + 10'd1;
        end
        bleft_nxt = bleft_r - 16'd1;
        done_nxt  = (bleft_r == 16'd1);
        finish    = 1'b1;
      end

      ST_READ_WAIT: begin
        rd_nxt = ~ram_rdata;
        finish = 1'b1;
      end

      ST_DONE: begin
        finish = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // advance to the next pixel of the request
    if (pix_done) begin
      unique case (op_r)
        REQ_FILL: begin
          if (px_inc < xlim_r) begin
            px_nxt    = px_inc;
            state_nxt = ST_PIX;
          end else if (py_inc < ylim_r) begin
            px_nxt    = {1'b0, x0_r};
            py_nxt    = py_inc;
            state_nxt = ST_PIX;
          end else begin
            finish = 1'b1;
          end
        end
        REQ_BLIT_BYTE: begin
          cur_x_nxt = cur_x_r + 10'd1;
          bcnt_nxt  = bcnt_r + 3'd1;
          bdata_nxt = {bdata_r[6:0], 1'b0};
          state_nxt = (bcnt_r == 3'd7) ? ST_BLIT_END : ST_BLIT_STEP;
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end

    // hand the result to the output register, or hold it while that is full
    if (finish) begin
      if (slot_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_nxt;
        out_rd_nxt     = rd_nxt;
        out_done_nxt   = done_nxt;
        state_nxt      = ST_IDLE;
      end else begin
        state_nxt = ST_DONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rot_r       <= ROT_0;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      org_x_r     <= '0;
      bw_r        <= '0;
      bleft_r     <= '0;
      bink_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      org_x_r     <= org_x_nxt;
      bw_r        <= bw_nxt;
      bleft_r     <= bleft_nxt;
      bink_r      <= bink_nxt;
      if (cfg_valid) begin
        rot_r <= rot_t'(cfg_rotation);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    colour_r     <= colour_nxt;
    x0_r         <= x0_nxt;
    xlim_r       <= xlim_nxt;
    ylim_r       <= ylim_nxt;
    bdata_r      <= bdata_nxt;
    bcnt_r       <= bcnt_nxt;
    addr_r       <= addr_nxt;
    mask_r       <= mask_nxt;
    status_r     <= status_nxt;
    rd_r         <= rd_nxt;
    done_r       <= done_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_done_r   <= out_done_nxt;
  end

endmodule
